// ===== hdl/bhte_pkg.sv =====
// Shared types, request/status codes and hash helpers for the bucketed hash table engine.
// Used by bhte_hash, bhte_bucket and bucketed_hash_table_engine_top.
package bhte_pkg;

    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 32;
    localparam int COUNT_OUT_W   = 10;
    localparam int STATUS_W      = 3;
    localparam int HASH_W        = 32;

    localparam logic [HASH_W-1:0] DJB2_SEED = 32'd5381;

    typedef logic [1:0]          req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_FIND   = 2'd1;
    localparam req_t REQ_REMOVE = 2'd2;
    localparam req_t REQ_CLEAR  = 2'd3;

    localparam status_t STAT_UPDATED  = 3'd0;
    localparam status_t STAT_INSERTED = 3'd1;
    localparam status_t STAT_HIT      = 3'd2;
    localparam status_t STAT_MISS     = 3'd3;
    localparam status_t STAT_FULL     = 3'd4;

    // Outcome of one bucket lookup, handed from the slot logic to the control.
    typedef struct packed {
        logic                     wr_en;
        logic                     cnt_inc;
        logic                     cnt_dec;
        status_t                  status;
        logic [VALUE_FIELD_W-1:0] value_out;
    } bucket_res_t;

    // 33**n modulo 2**32, evaluated at elaboration
    function automatic logic [HASH_W-1:0] pow33(input int n);
        logic [HASH_W-1:0] r;
        r = 32'd1;
        for (int i = 0; i < n; i++)
        begin
            r = HASH_W'(r * 32'd33);
        end
        return r;
    endfunction

endpackage

// ===== hdl/bhte_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bhte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bhte_hash.sv =====
// djb2 bucket selection: closed-form hash of the key bytes, then reduction to a bucket index.
// Depends on bhte_pkg.
module bhte_hash #(
    parameter int BUCKET_COUNT = 64,
    parameter int KEY_BYTES    = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [bhte_pkg::KEY_FIELD_W-1:0]     key,
    output logic                                 done,
    output logic [$clog2(BUCKET_COUNT)-1:0]      bucket
);
    import bhte_pkg::*;

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int FIELD_BYTES = KEY_FIELD_W / 8;
    localparam logic [HASH_W-1:0] SEED_TERM = HASH_W'(DJB2_SEED * pow33(KEY_BYTES));

    logic [FIELD_BYTES-1:0][HASH_W-1:0] term;
    logic [HASH_W-1:0]                  h_next;

    // h = seed*33^N + sum of byte_i * 33^(N-1-i); field bytes at or past KEY_BYTES give zero terms
    for (genvar g = 0; g < FIELD_BYTES; g++)
    begin : g_term
        if (g < KEY_BYTES)
        begin : g_used
            localparam logic [HASH_W-1:0] WEIGHT = pow33(KEY_BYTES - 1 - g);
            assign term[g] = HASH_W'(HASH_W'(key[8*g +: 8]) * WEIGHT);
        end
        else
        begin : g_unused
            assign term[g] = '0;
        end
    end

    always_comb
    begin
        h_next = SEED_TERM;
        for (int i = 0; i < FIELD_BYTES; i++)
        begin
            h_next = h_next + term[i];
        end
    end

    if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0)
    begin : g_mask
        logic [HASH_W-1:0] h_reg;
        logic              done_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                h_reg <= h_next;
            end
        end

        assign done   = done_reg;
        assign bucket = h_reg[BW-1:0];
    end
    else
    begin : g_mod
        // reciprocal multiply gives a quotient at most one short, so one
        // compare and subtract on the low bits finishes the remainder
        localparam int RW = BW + 1;
        localparam logic [HASH_W-1:0] RECIP =
            HASH_W'(64'h1_0000_0000 / 64'(BUCKET_COUNT));
        localparam logic [RW-1:0] DIVISOR = RW'(BUCKET_COUNT);

        logic [HASH_W-1:0]   h_reg;
        logic [2*HASH_W-1:0] prod;
        logic [RW-1:0]       quo_low_reg;
        logic [RW-1:0]       h_low_reg;
        logic [RW-1:0]       quo_times_div;
        logic [RW-1:0]       rem_est;
        logic [RW-1:0]       rem_fix;
        logic                stage1_reg;
        logic                done_reg;

        assign prod          = (2*HASH_W)'(h_reg) * (2*HASH_W)'(RECIP);
        assign quo_times_div = quo_low_reg * DIVISOR;
        assign rem_est       = h_low_reg - quo_times_div;
        assign rem_fix       = (rem_est >= DIVISOR) ? rem_est - DIVISOR : rem_est;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage1_reg <= 1'b0;
                done_reg   <= 1'b0;
            end
            else
            begin
                stage1_reg <= start;
                done_reg   <= stage1_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                h_reg <= h_next;
            end
            if (stage1_reg)
            begin
                quo_low_reg <= prod[HASH_W +: RW];
                h_low_reg   <= h_reg[RW-1:0];
            end
        end

        assign done   = done_reg;
        assign bucket = rem_fix[BW-1:0];
    end

endmodule

// ===== hdl/bhte_bucket.sv =====
// Slot compare and row modify for one bucket row: hit search, free-slot search, write-back data.
// Depends on bhte_pkg.
module bhte_bucket #(
    parameter int SLOTS = 8,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic                              row_live,
    input  logic [SLOTS*(KEY_W+VAL_W+1)-1:0]  row_in,
    input  bhte_pkg::req_t                    req,
    input  logic [KEY_W-1:0]                  key,
    input  logic [VAL_W-1:0]                  value,
    input  logic                              count_nonzero,
    output logic [SLOTS*(KEY_W+VAL_W+1)-1:0]  row_out,
    output bhte_pkg::bucket_res_t             res
);
    import bhte_pkg::*;

    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VAL_BASE = SLOTS * KEY_W;
    localparam int MASK_BASE = SLOTS * (KEY_W + VAL_W);

    logic [SLOTS-1:0] mask;
    logic [SLOTS-1:0] match;
    logic             hit_found;
    logic [SW-1:0]    hit_idx;
    logic             free_found;
    logic [SW-1:0]    free_idx;
    logic [VAL_W-1:0] hit_value;

    // a row never written since reset or clear has no live slots
    assign mask = row_live ? row_in[MASK_BASE +: SLOTS] : '0;

    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            match[s] = mask[s] && (row_in[s*KEY_W +: KEY_W] == key);
        end
        // scan downward so the lowest slot wins
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                hit_found = 1'b1;
                hit_idx   = SW'(s);
            end
            if (!mask[s])
            begin
                free_found = 1'b1;
                free_idx   = SW'(s);
            end
        end
    end

    always_comb
    begin
        hit_value = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (SW'(s) == hit_idx)
            begin
                hit_value = row_in[VAL_BASE + s*VAL_W +: VAL_W];
            end
        end
    end

    always_comb
    begin
        row_out = row_in;
        row_out[MASK_BASE +: SLOTS] = mask;
        res.wr_en     = 1'b0;
        res.cnt_inc   = 1'b0;
        res.cnt_dec   = 1'b0;
        res.status    = STAT_MISS;
        res.value_out = '0;
        case (req)
            REQ_INSERT:
            begin
                res.wr_en = hit_found || free_found;
                if (hit_found)
                begin
                    res.status = STAT_UPDATED;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (SW'(s) == hit_idx)
                        begin
                            row_out[VAL_BASE + s*VAL_W +: VAL_W] = value;
                        end
                    end
                end
                else if (free_found)
                begin
                    res.status  = STAT_INSERTED;
                    res.cnt_inc = 1'b1;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (SW'(s) == free_idx)
                        begin
                            row_out[s*KEY_W +: KEY_W]              = key;
                            row_out[VAL_BASE + s*VAL_W +: VAL_W]   = value;
                            row_out[MASK_BASE + s]                 = 1'b1;
                        end
                    end
                end
                else
                begin
                    res.status = STAT_FULL;
                end
            end
            REQ_FIND:
            begin
                if (hit_found)
                begin
                    res.status    = STAT_HIT;
                    res.value_out = VALUE_FIELD_W'(hit_value);
                end
            end
            REQ_REMOVE:
            begin
                if (hit_found)
                begin
                    res.status  = STAT_HIT;
                    res.wr_en   = 1'b1;
                    res.cnt_dec = count_nonzero;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (SW'(s) == hit_idx)
                        begin
                            row_out[MASK_BASE + s] = 1'b0;
                        end
                    end
                end
            end
            REQ_CLEAR:
            begin
                res.status = STAT_HIT;
            end
            default:
            begin
                res.status = STAT_MISS;
            end
        endcase
    end

endmodule

// ===== hdl/bucketed_hash_table_engine_top.sv =====
// Top level of the bucketed hash table engine: request control, row memory, counters, output.
// Depends on bhte_pkg, bhte_hash, bhte_bucket and bhte_ram.
//
// Usage:
//   Requests enter on in_valid/in_stall with req_type, key and value; each request
//   gives exactly one result on out_valid/out_stall with status, value_out and
//   entry_count. A transfer happens on a clock edge where valid is high and stall low.
//   Each bucket is one row of the table memory: the live-slot mask, all keys and all
//   values of its slots. A request reads its row once, compares every slot in
//   parallel, and writes the modified row back in the same cycle it produces its result.
//   With a power-of-two bucket count the key hash is registered, then the row is read,
//   then the result is registered, and only then is a new request taken. With
//   any other bucket count the bucket index comes from a reciprocal-multiply remainder
//   unit that registers its quotient before the remainder. in_stall is high from
//   acceptance until the result is registered; one request is in flight at a time.
//   A result waiting under out_stall holds back the next request's write-back and
//   result, so stalling the output stalls the engine, but one new request may be
//   taken, hashed and have its row read meanwhile.
//   Reset (rst_n low, asynchronous) empties the table at once: a flop per bucket row
//   marks the row live, so no clearing pass is needed. A clear request drops those
//   flops and the entry count together.
module bucketed_hash_table_engine_top #(
    parameter int BUCKET_COUNT     = 64,
    parameter int SLOTS_PER_BUCKET = 8,
    parameter int KEY_BYTES        = 4,
    parameter int VALUE_BYTES      = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  bhte_pkg::req_t                         req_type,
    input  logic [bhte_pkg::KEY_FIELD_W-1:0]       key,
    input  logic [bhte_pkg::VALUE_FIELD_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output bhte_pkg::status_t                      status,
    output logic [bhte_pkg::VALUE_FIELD_W-1:0]     value_out,
    output logic [bhte_pkg::COUNT_OUT_W-1:0]       entry_count
);
    import bhte_pkg::*;

    localparam int KEY_W  = 8 * ((KEY_BYTES < KEY_FIELD_W / 8) ? KEY_BYTES : KEY_FIELD_W / 8);
    localparam int VAL_W  = 8 * ((VALUE_BYTES < VALUE_FIELD_W / 8) ?
                                 VALUE_BYTES : VALUE_FIELD_W / 8);
    localparam int ROW_W  = SLOTS_PER_BUCKET * (KEY_W + VAL_W + 1);
    localparam int BW     = $clog2(BUCKET_COUNT);
    localparam int TOTAL  = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int CNT_RAW_W = $clog2(TOTAL + 1);
    localparam int CNT_W  = (CNT_RAW_W > COUNT_OUT_W) ? CNT_RAW_W : COUNT_OUT_W;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_HASH    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    req_t                    req_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [VAL_W-1:0]        value_reg;
    logic [BW-1:0]           bucket_reg;
    logic [BUCKET_COUNT-1:0] row_live_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [VALUE_FIELD_W-1:0] value_out_reg;

    logic                    in_take;
    logic                    hash_done;
    logic [BW-1:0]           hash_bucket;
    logic                    rd_issue;
    logic                    resolve_go;
    logic [ROW_W-1:0]        row_rd;
    logic [ROW_W-1:0]        row_wr;
    bucket_res_t             res;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign rd_issue = (state_reg == ST_HASH) && hash_done;
    // retire only when the output register is free or being drained
    assign resolve_go = (state_reg == ST_RESOLVE) && (!out_valid_reg || !out_stall);

    bhte_hash #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .KEY_BYTES    (KEY_BYTES)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_take),
        .key    (key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    bhte_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKET_COUNT)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (resolve_go && res.wr_en),
        .wr_addr (bucket_reg),
        .wr_data (row_wr),
        .rd_en   (rd_issue),
        .rd_addr (hash_bucket),
        .rd_data (row_rd)
    );

    bhte_bucket #(
        .SLOTS (SLOTS_PER_BUCKET),
        .KEY_W (KEY_W),
        .VAL_W (VAL_W)
    ) u_bucket (
        .row_live      (row_live_reg[bucket_reg]),
        .row_in        (row_rd),
        .req           (req_reg),
        .key           (key_reg),
        .value         (value_reg),
        .count_nonzero (count_reg != '0),
        .row_out       (row_wr),
        .res           (res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (resolve_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_live_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (resolve_go)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg == REQ_CLEAR)
                begin
                    // drop every row and the count in one step
                    row_live_reg <= '0;
                    count_reg    <= '0;
                end
                else
                begin
                    if (res.wr_en)
                    begin
                        row_live_reg[bucket_reg] <= 1'b1;
                    end
                    if (res.cnt_inc)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (res.cnt_dec)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg   <= req_type;
            key_reg   <= key[KEY_W-1:0];
            value_reg <= value[VAL_W-1:0];
        end
        if (rd_issue)
        begin
            bucket_reg <= hash_bucket;
        end
        if (resolve_go)
        begin
            status_reg    <= res.status;
            value_out_reg <= res.value_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_reg[COUNT_OUT_W-1:0];

endmodule

// ===== tb/bucketed_hash_table_engine_top_tb.sv =====
// Self-checking testbench for bucketed_hash_table_engine_top: directed and random table requests.
// The table is mirrored in the bench; depends on bhte_pkg and the engine RTL only.
module bucketed_hash_table_engine_top_tb;
    import bhte_pkg::*;

    localparam int BUCKETS         = 64;
    localparam int SLOTS           = 8;
    localparam int RANDOM_REQUESTS = 1230;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;

    // What one request should return.
    typedef struct packed {
        status_t                  status;
        logic [VALUE_FIELD_W-1:0] value_out;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } table_outcome_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    req_t                     req_type  = REQ_FIND;
    logic [KEY_FIELD_W-1:0]   key       = '0;
    logic [VALUE_FIELD_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    status_t                  status;
    logic [VALUE_FIELD_W-1:0] value_out;
    logic [COUNT_OUT_W-1:0]   entry_count;

    // Mirror of the table contents; keys and values are only read where the slot is live.
    bit                       mirror_live  [BUCKETS*SLOTS];
    logic [KEY_FIELD_W-1:0]   mirror_key   [BUCKETS*SLOTS];
    logic [VALUE_FIELD_W-1:0] mirror_value [BUCKETS*SLOTS];
    int unsigned              mirror_count;

    table_outcome_t           pending_outcomes[$];
    logic [KEY_FIELD_W-1:0]   known_keys[$];
    int unsigned              mismatch_count;
    int unsigned              cycle_count;
    bit                       quiet;

    bucketed_hash_table_engine_top #(
        .BUCKET_COUNT     (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS),
        .KEY_BYTES        (4),
        .VALUE_BYTES      (4)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Kill a hung run.
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // djb2 over the four key bytes, byte 0 first, reduced to a bucket index.
    function automatic int unsigned bucket_of(logic [KEY_FIELD_W-1:0] k);
        logic [HASH_W-1:0] h;
        h = DJB2_SEED;
        for (int i = 0; i < 4; i++)
        begin
            h = h * 32'd33 + {24'd0, k[8*i +: 8]};
        end
        return h % BUCKETS;
    endfunction

    // Draw random keys until one lands in bucket b.
    function automatic logic [KEY_FIELD_W-1:0] key_for_bucket(int unsigned b);
        logic [KEY_FIELD_W-1:0] k;
        do
        begin
            k = $urandom;
        end
        while (bucket_of(k) != b);
        return k;
    endfunction

    // Mostly reuse a key seen before so lookups hit; otherwise a fresh random key.
    function automatic logic [KEY_FIELD_W-1:0] recall_key();
        if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        end
        return $urandom;
    endfunction

    // Apply one request to the mirror and return what the engine must answer.
    function automatic table_outcome_t apply_request(req_t rt, logic [KEY_FIELD_W-1:0] k,
                                                     logic [VALUE_FIELD_W-1:0] v);
        table_outcome_t r;
        int             base;
        int             hit;
        int             free_slot;
        r.status    = STAT_MISS;
        r.value_out = '0;
        if (rt == REQ_CLEAR)
        begin
            foreach (mirror_live[i])
            begin
                mirror_live[i] = 1'b0;
            end
            mirror_count = 0;
            r.status     = STAT_HIT;
        end
        else
        begin
            base      = bucket_of(k) * SLOTS;
            hit       = -1;
            free_slot = -1;
            // First matching live slot wins; new entries take the lowest free slot.
            for (int s = 0; s < SLOTS; s++)
            begin
                if (mirror_live[base + s])
                begin
                    if (hit < 0 && mirror_key[base + s] == k)
                        hit = s;
                end
                else if (free_slot < 0)
                begin
                    free_slot = s;
                end
            end
            case (rt)
                REQ_INSERT:
                begin
                    if (hit >= 0)
                    begin
                        mirror_value[base + hit] = v;
                        r.status = STAT_UPDATED;
                    end
                    else if (free_slot >= 0)
                    begin
                        mirror_live[base + free_slot]  = 1'b1;
                        mirror_key[base + free_slot]   = k;
                        mirror_value[base + free_slot] = v;
                        mirror_count++;
                        r.status = STAT_INSERTED;
                    end
                    else
                    begin
                        r.status = STAT_FULL;
                    end
                end
                REQ_FIND:
                begin
                    if (hit >= 0)
                    begin
                        r.value_out = mirror_value[base + hit];
                        r.status    = STAT_HIT;
                    end
                end
                default:
                begin
                    if (hit >= 0)
                    begin
                        mirror_live[base + hit] = 1'b0;
                        if (mirror_count > 0)
                            mirror_count--;
                        r.status = STAT_HIT;
                    end
                end
            endcase
        end
        r.entry_count = COUNT_OUT_W'(mirror_count);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Send one request: idle for a random gap, hold the payload until taken, then
    // record the expected answer. Called in the time step of a rising edge.
    task automatic send_request(req_t rt, logic [KEY_FIELD_W-1:0] k,
                                logic [VALUE_FIELD_W-1:0] v);
        int gap;
        bit taken;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        key      <= k;
        value    <= v;
        taken = 1'b0;
        // Sample stall mid-cycle, where it has settled; the next edge takes the request.
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pending_outcomes.push_back(apply_request(rt, k, v));
    endtask

    // Result side: stall a random number of cycles before each result, sample the
    // fields mid-cycle and compare them against the oldest expected answer.
    initial
    begin : result_checker
        int                       hold;
        bit                       took;
        table_outcome_t           want;
        status_t                  got_status;
        logic [VALUE_FIELD_W-1:0] got_value;
        logic [COUNT_OUT_W-1:0]   got_count;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 3);
            out_stall <= (hold != 0);
            while (hold > 0)
            begin
                @(posedge clk);
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took       = out_valid && !out_stall;
                got_status = status;
                got_value  = value_out;
                got_count  = entry_count;
                @(posedge clk);
            end
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %0d value_out %h count %0d",
                                          got_status, got_value, got_count));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got_status, want.status));
                if (got_value !== want.value_out)
                    report_mismatch($sformatf("value_out %h, expected %h",
                                              got_value, want.value_out));
                if (got_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              got_count, want.entry_count));
            end
        end
    end

    // Lookups and removals on an empty table, including the key extremes.
    task automatic test_empty_table();
        send_request(REQ_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Insert the extreme keys with extreme values, then update one and read both back.
    task automatic test_insert_and_update();
        send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill one bucket, overflow it, free a middle slot and check the refill lands there.
    task automatic test_full_bucket();
        logic [KEY_FIELD_W-1:0] crowd[SLOTS+1];
        int unsigned            b;
        b = $urandom_range(0, BUCKETS - 1);
        while (b == bucket_of(32'h0000_0000) || b == bucket_of(32'hFFFF_FFFF))
        begin
            b = $urandom_range(0, BUCKETS - 1);
        end
        foreach (crowd[i])
        begin
            crowd[i] = key_for_bucket(b);
        end
        foreach (crowd[i])
        begin
            send_request(REQ_INSERT, crowd[i], $urandom);
        end
        send_request(REQ_REMOVE, crowd[2], $urandom);
        send_request(REQ_INSERT, crowd[SLOTS], $urandom);
        send_request(REQ_FIND, crowd[SLOTS], $urandom);
        // Update still works while the bucket is full.
        send_request(REQ_INSERT, crowd[0], $urandom);
    endtask

    // Clear everything, then confirm an old key is gone.
    task automatic test_clear_all();
        send_request(REQ_CLEAR, $urandom, $urandom);
        send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Mixed traffic: reused keys so lookups hit, a few hot buckets that overflow,
    // misses on random keys and the occasional clear. Idling switches off in stretches.
    task automatic test_random_traffic();
        int unsigned            hot[4];
        int unsigned            pick;
        logic [KEY_FIELD_W-1:0] k;
        foreach (hot[i])
        begin
            hot[i] = $urandom_range(0, BUCKETS - 1);
        end
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 499);
            if (pick < 200)
            begin
                case ($urandom_range(0, 3))
                    0: k = $urandom;
                    1: k = key_for_bucket(hot[$urandom_range(0, 3)]);
                    default: k = recall_key();
                endcase
                // Keep the pool of reusable keys bounded.
                if (known_keys.size() < 200)
                    known_keys.push_back(k);
                else
                    known_keys[$urandom_range(0, known_keys.size() - 1)] = k;
                send_request(REQ_INSERT, k, $urandom);
            end
            else if (pick < 340)
            begin
                send_request(REQ_FIND, recall_key(), $urandom);
            end
            else if (pick < 498)
            begin
                send_request(REQ_REMOVE, recall_key(), $urandom);
            end
            else
            begin
                send_request(REQ_CLEAR, $urandom, $urandom);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin : run_tests
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_insert_and_update();
        test_full_bucket();
        test_clear_all();
        test_random_traffic();
        in_valid <= 1'b0;
        // Drain outstanding results, then hold a little longer to catch strays.
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
